// ===== src/pleng_pkg.sv =====
// Package for the positional list engine: sizes, codes and the cell control type.
`default_nettype none
package pleng_pkg;

  // Number of list entries, one cell per entry.
  localparam int CAPACITY = 256;

  // Widths of the external fields.
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 9;
  localparam int LEN_W  = 9;
  localparam int STAT_W = 2;

  // Internal widths that follow from the capacity.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Read gather: cells are OR-ed in groups, then the group results are OR-ed.
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_UPDATE = 3'd3,
    OP_GET    = 3'd4,
    OP_DELETE = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } cell_act_e;

  typedef struct packed {
    cell_act_e        act;
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_REDUCE = 1'b1
  } state_e;

endpackage
`default_nettype wire

// ===== src/pleng_cell.sv =====
// One list cell: holds one element and shifts to or from its neighbours.
`default_nettype none
module pleng_cell (
  input  wire logic                                 clk_i,
  input  wire logic        [pleng_pkg::IDX_W-1:0]   cell_idx_i,
  input  wire pleng_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic signed [pleng_pkg::DATA_W-1:0]  value_i,
  input  wire logic signed [pleng_pkg::DATA_W-1:0]  left_i,
  input  wire logic signed [pleng_pkg::DATA_W-1:0]  right_i,
  output      logic signed [pleng_pkg::DATA_W-1:0]  data_o,
  output      logic signed [pleng_pkg::DATA_W-1:0]  rd_o
);

  logic signed [pleng_pkg::DATA_W-1:0] data_q;
  logic signed [pleng_pkg::DATA_W-1:0] data_d;
  logic                                hit;
  logic                                above;

  assign hit   = (cell_idx_i == ctrl_i.idx);
  assign above = (cell_idx_i > ctrl_i.idx);

  // Next element: write, take from the left on insert, from the right on delete.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.act)
      pleng_pkg::ACT_WRITE: begin
        if (hit) data_d = value_i;
      end
      pleng_pkg::ACT_INSERT: begin
        if (hit) data_d = value_i;
        else if (above) data_d = left_i;
      end
      pleng_pkg::ACT_DELETE: begin
        if (hit || above) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives its element onto the read gather.
  assign rd_o   = hit ? data_q : '0;

endmodule
`default_nettype wire

// ===== src/positional_list_engine_unit.sv =====
// Top level of the positional list engine: decode, cell chain and result register.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_ready_o  op_i, position_i, value_i
//   output   out        out_valid_o / out_ready_i status_o, read_value_o, length_o
//
// For a command, the cells shift or write at the accepting edge while the addressed
// element is gathered into group registers; the S_REDUCE state then combines the groups
// into the result register. One command is in flight at a time.
// Reset clears the list length and the handshake state; the cells need no clearing.
// A new command is taken while an earlier result still waits to be taken; the
// gather cycle stalls until the result register is free.
`default_nettype none
module positional_list_engine_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic        [pleng_pkg::OP_W-1:0]    op_i,
  input  wire logic        [pleng_pkg::POS_W-1:0]   position_i,
  input  wire logic signed [pleng_pkg::DATA_W-1:0]  value_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      logic        [pleng_pkg::STAT_W-1:0]  status_o,
  output      logic signed [pleng_pkg::DATA_W-1:0]  read_value_o,
  output      logic        [pleng_pkg::LEN_W-1:0]   length_o
);

  localparam int CMP_W = pleng_pkg::CMP_W;
  localparam int CNT_W = pleng_pkg::CNT_W;
  localparam int IDX_W = pleng_pkg::IDX_W;

  // Control registers.
  pleng_pkg::state_e      state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   load_out;

  // Per-command registers.
  pleng_pkg::status_e     stat_q;
  logic                   get_q;

  // Result registers.
  pleng_pkg::status_e     res_stat_q;
  logic signed [pleng_pkg::DATA_W-1:0] res_value_q;
  logic [pleng_pkg::LEN_W-1:0]         res_len_q;

  // Decode signals.
  logic                   in_fire;
  logic [CMP_W-1:0]       pos_w;
  logic [CMP_W-1:0]       cnt_w;
  logic                   in_list;
  logic                   full;
  logic [IDX_W-1:0]       pos_idx;
  pleng_pkg::cell_ctrl_t  dec_ctrl;
  pleng_pkg::cell_ctrl_t  ctrl;
  pleng_pkg::status_e     dec_stat;
  logic                   dec_get;
  logic [CNT_W-1:0]       dec_count;

  assign in_ready_o = (state_q == pleng_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_w   = CMP_W'(position_i);
  assign cnt_w   = CMP_W'(count_q);
  assign in_list = (pos_w != '0) && (pos_w <= cnt_w);
  assign full    = (count_q >= CNT_W'(pleng_pkg::CAPACITY));
  assign pos_idx = IDX_W'(pos_w - CMP_W'(1));

  // Command decode: status, new length and the action for the cell chain.
  always_comb begin
    dec_ctrl.act = pleng_pkg::ACT_HOLD;
    dec_ctrl.idx = pos_idx;
    dec_stat     = pleng_pkg::STAT_OK;
    dec_get      = 1'b0;
    dec_count    = count_q;
    case (pleng_pkg::op_e'(op_i))
      pleng_pkg::OP_INIT: begin
        dec_ctrl.act = pleng_pkg::ACT_WRITE;
        dec_ctrl.idx = '0;
        dec_count    = CNT_W'(1);
      end
      pleng_pkg::OP_APPEND: begin
        if (full) begin
          dec_stat = pleng_pkg::STAT_FULL;
        end else begin
          dec_ctrl.act = pleng_pkg::ACT_WRITE;
          dec_ctrl.idx = IDX_W'(count_q);
          dec_count    = CNT_W'(count_q + CNT_W'(1));
        end
      end
      pleng_pkg::OP_INSERT: begin
        if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1))) begin
          dec_stat = pleng_pkg::STAT_RANGE;
        end else if (full) begin
          dec_stat = pleng_pkg::STAT_FULL;
        end else begin
          dec_ctrl.act = pleng_pkg::ACT_INSERT;
          dec_count    = CNT_W'(count_q + CNT_W'(1));
        end
      end
      pleng_pkg::OP_UPDATE: begin
        if (in_list) dec_ctrl.act = pleng_pkg::ACT_WRITE;
        else dec_stat = pleng_pkg::STAT_RANGE;
      end
      pleng_pkg::OP_GET: begin
        if (in_list) dec_get = 1'b1;
        else dec_stat = pleng_pkg::STAT_RANGE;
      end
      pleng_pkg::OP_DELETE: begin
        if (in_list) begin
          dec_ctrl.act = pleng_pkg::ACT_DELETE;
          dec_count    = CNT_W'(count_q - CNT_W'(1));
        end else begin
          dec_stat = pleng_pkg::STAT_RANGE;
        end
      end
      default: dec_stat = pleng_pkg::STAT_RANGE;
    endcase
  end

  // The cells act only at the edge that accepts a transaction.
  always_comb begin
    ctrl     = dec_ctrl;
    if (!in_fire) ctrl.act = pleng_pkg::ACT_HOLD;
  end

  // Cell chain.
  logic signed [pleng_pkg::DATA_W-1:0] cell_data [pleng_pkg::CAPACITY];
  logic signed [pleng_pkg::DATA_W-1:0] cell_rd   [pleng_pkg::CAPACITY];

  for (genvar i = 0; i < pleng_pkg::CAPACITY; i++) begin : g_cell
    logic signed [pleng_pkg::DATA_W-1:0] left_w;
    logic signed [pleng_pkg::DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == pleng_pkg::CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    pleng_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .value_i    (value_i),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // First gather stage: OR of each group of cells, registered.
  logic signed [pleng_pkg::DATA_W-1:0] grp_d [pleng_pkg::NUM_GROUPS];
  logic signed [pleng_pkg::DATA_W-1:0] grp_q [pleng_pkg::NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < pleng_pkg::NUM_GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < pleng_pkg::GROUP_SIZE; j++) begin
        if (g * pleng_pkg::GROUP_SIZE + j < pleng_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * pleng_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int g = 0; g < pleng_pkg::NUM_GROUPS; g++) begin
        grp_q[g] <= grp_d[g];
      end
      stat_q <= dec_stat;
      get_q  <= dec_get;
    end
  end

  // Second gather stage: OR of the groups.
  logic signed [pleng_pkg::DATA_W-1:0] gather;

  always_comb begin
    gather = '0;
    for (int g = 0; g < pleng_pkg::NUM_GROUPS; g++) begin
      gather = gather | grp_q[g];
    end
  end

  // Sequencer: next state and result register control.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    count_d     = in_fire ? dec_count : count_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      pleng_pkg::S_IDLE: begin
        if (in_fire) state_d = pleng_pkg::S_REDUCE;
      end
      pleng_pkg::S_REDUCE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pleng_pkg::S_IDLE;
        end
      end
      default: state_d = pleng_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pleng_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_stat_q  <= stat_q;
      res_value_q <= get_q ? gather : '0;
      res_len_q   <= pleng_pkg::LEN_W'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_stat_q;
  assign read_value_o = res_value_q;
  assign length_o     = res_len_q;

`ifndef SYNTHESIS
  // The list never grows beyond its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(pleng_pkg::CAPACITY))
    else $error("list length exceeds capacity");

  // A full status is only reported when the list is at capacity.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == pleng_pkg::STAT_FULL))
      |-> (length_o == pleng_pkg::LEN_W'(pleng_pkg::CAPACITY)))
    else $error("full status with a list below capacity");

  // A non-zero read value only comes with a successful command.
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_value_o != '0)) |-> (status_o == pleng_pkg::STAT_OK))
    else $error("read value returned with a failing status");

  // Init always leaves exactly one element.
  a_init_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == pleng_pkg::OP_INIT)) |=> (count_q == CNT_W'(1)))
    else $error("init did not leave one element");
`endif

endmodule
`default_nettype wire

// ===== dv/pleng_list_checker.sv =====
// Checker for the positional list engine: tracks the list, predicts each result and compares.
module pleng_list_checker
  import pleng_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [OP_W-1:0]          op_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [STAT_W-1:0]        status_i,
  input  logic signed [DATA_W-1:0] read_value_i,
  input  logic [LEN_W-1:0]         length_i,
  output int unsigned              error_count_o,
  output int unsigned              pending_o
);

  // One result transaction as the block should return it.
  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  // Private copy of the list contents and its length.
  logic signed [DATA_W-1:0] shadow_elems [CAPACITY];
  int                       shadow_len;

  // Results still owed by the block, oldest first.
  list_result_t             owed_results [$];
  int unsigned              error_total;
  list_result_t             seen_result;
  list_result_t             owed_result;
  int unsigned              errs;

  // Applies one command to the private list and returns the result it must give.
  function automatic list_result_t apply_list_command(input logic [OP_W-1:0] op,
                                                      input logic [POS_W-1:0] pos_bits,
                                                      input logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           p;
    int           k;
    logic         in_list;
    res.status     = STAT_OK;
    res.read_value = '0;
    p              = int'(pos_bits);
    in_list        = (p >= 1) && (p <= shadow_len);
    case (op)
      OP_INIT: begin
        shadow_elems[0] = val;
        shadow_len      = 1;
      end
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          shadow_elems[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // The position is judged before the free space.
        if (p < 1 || p > shadow_len + 1) begin
          res.status = STAT_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          for (k = shadow_len; k > p - 1; k--) shadow_elems[k] = shadow_elems[k-1];
          shadow_elems[p-1] = val;
          shadow_len++;
        end
      end
      OP_UPDATE: begin
        if (!in_list) res.status = STAT_RANGE;
        else shadow_elems[p-1] = val;
      end
      OP_GET: begin
        if (!in_list) res.status = STAT_RANGE;
        else res.read_value = shadow_elems[p-1];
      end
      OP_DELETE: begin
        if (!in_list) begin
          res.status = STAT_RANGE;
        end else begin
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_elems[k] = shadow_elems[k+1];
          shadow_len--;
        end
      end
      // Spare op codes leave the list alone and report a range error.
      default: res.status = STAT_RANGE;
    endcase
    res.length = LEN_W'(shadow_len);
    return res;
  endfunction

  // Reports one differing field and returns how many errors that makes.
  function automatic int unsigned field_mismatch(input string field, input longint want,
                                                 input longint got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    return 1;
  endfunction

  // Results are checked before new commands are predicted, since a result
  // taken in the same cycle always belongs to an older command.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      owed_results.delete();
      error_total = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      errs = error_total;
      if (out_valid_i && out_ready_i) begin
        seen_result.status     = status_e'(status_i);
        seen_result.read_value = read_value_i;
        seen_result.length     = length_i;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result transaction, status %0d read_value %0d length %0d",
                   $time, status_i, read_value_i, length_i);
          errs++;
        end else begin
          owed_result = owed_results.pop_front();
          errs += field_mismatch("status", owed_result.status, seen_result.status);
          errs += field_mismatch("read_value", owed_result.read_value, seen_result.read_value);
          errs += field_mismatch("length", owed_result.length, seen_result.length);
        end
      end
      if (in_valid_i && in_ready_i) begin
        owed_results.push_back(apply_list_command(op_i, position_i, value_i));
      end
      error_total = errs;
      error_count_o <= errs;
      pending_o     <= owed_results.size();
    end
  end

endmodule

// ===== dv/positional_list_engine_unit_tb.sv =====
// Testbench top for the positional list engine: clock, reset, command stimulus and verdict.
module positional_list_engine_unit_tb;
  import pleng_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 9;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int TOTAL_COMMANDS   = 600;
  localparam int QUIET_TAIL       = 80;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES    = 8;
  localparam int MAX_POSITION     = (1 << POS_W) - 1;

  // Op codes that the block does not define.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cmd_valid      = 1'b0;
  logic                     cmd_ready;
  logic [OP_W-1:0]          cmd_op         = '0;
  logic [POS_W-1:0]         cmd_position   = '0;
  logic signed [DATA_W-1:0] cmd_value      = '0;
  logic                     res_valid;
  logic                     res_ready      = 1'b0;
  logic [STAT_W-1:0]        res_status;
  logic signed [DATA_W-1:0] res_read_value;
  logic [LEN_W-1:0]         res_length;

  int unsigned              mismatch_count;
  int unsigned              open_results;

  // Stimulus bookkeeping.
  int                       tracked_length = 0;
  int                       commands_sent  = 0;
  int                       results_seen   = 0;
  int                       full_reached   = 0;
  int unsigned              cycle_count    = 0;
  bit                       quiet_tail     = 1'b0;
  bit                       tx_calm        = 1'b0;
  bit                       hold_request   = 1'b0;
  bit                       hold_done      = 1'b0;

  positional_list_engine_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (cmd_valid),
    .in_ready_o   (cmd_ready),
    .op_i         (cmd_op),
    .position_i   (cmd_position),
    .value_i      (cmd_value),
    .out_valid_o  (res_valid),
    .out_ready_i  (res_ready),
    .status_o     (res_status),
    .read_value_o (res_read_value),
    .length_o     (res_length)
  );

  pleng_list_checker list_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (cmd_valid),
    .in_ready_i    (cmd_ready),
    .op_i          (cmd_op),
    .position_i    (cmd_position),
    .value_i       (cmd_value),
    .out_valid_i   (res_valid),
    .out_ready_i   (res_ready),
    .status_i      (res_status),
    .read_value_i  (res_read_value),
    .length_i      (res_length),
    .error_count_o (mismatch_count),
    .pending_o     (open_results)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Count result transactions for the summary.
  always @(posedge clk) begin
    if (res_valid && res_ready) results_seen++;
  end

  // Element values, with the extremes and the all-ones pattern drawn often.
  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -1;
      default: return $urandom();
    endcase
  endfunction

  // Positions are mostly inside the list, sometimes just outside or anywhere.
  function automatic int rand_position(input logic [OP_W-1:0] op);
    int last;
    int r;
    last = (op == OP_INSERT) ? tracked_length + 1 : tracked_length;
    r    = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, MAX_POSITION);
    if (r == 1) return ($urandom_range(0, 1) == 0) ? 0 : last + 1;
    if (last < 1) return 1;
    return $urandom_range(1, last);
  endfunction

  // Offers one command transaction, after an occasional idle burst, and waits
  // until the block takes it.
  task automatic send_command(input logic [OP_W-1:0] op, input int pos,
                              input logic signed [DATA_W-1:0] val);
    int prev_length;
    if (!quiet_tail && !tx_calm && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_valid    <= 1'b1;
    cmd_op       <= op;
    cmd_position <= POS_W'(pos);
    cmd_value    <= val;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    // Follow the length so that later positions can be aimed inside the list.
    prev_length = tracked_length;
    case (op)
      OP_INIT:   tracked_length = 1;
      OP_APPEND: if (tracked_length < CAPACITY) tracked_length++;
      OP_INSERT: begin
        if (pos >= 1 && pos <= tracked_length + 1 && tracked_length < CAPACITY) begin
          tracked_length++;
        end
      end
      OP_DELETE: if (pos >= 1 && pos <= tracked_length) tracked_length--;
      default: ;
    endcase
    if (tracked_length == CAPACITY && prev_length != CAPACITY) full_reached++;
    commands_sent++;
    if (commands_sent % 32 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    if (commands_sent >= TOTAL_COMMANDS - QUIET_TAIL) quiet_tail = 1'b1;
  endtask

  // A random command with the op mix weighted towards growing the list.
  task automatic send_random_command();
    int               r;
    logic [OP_W-1:0]  op;
    r = $urandom_range(0, 99);
    if (r < 3)       op = OP_INIT;
    else if (r < 28) op = OP_APPEND;
    else if (r < 48) op = OP_INSERT;
    else if (r < 62) op = OP_UPDATE;
    else if (r < 82) op = OP_GET;
    else if (r < 95) op = OP_DELETE;
    else             op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    send_command(op, rand_position(op), rand_value());
  endtask

  // Stops offering commands until every owed result has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off, and none near the end.
  initial begin : result_sink
    int  hold_left;
    int  window;
    bit  rx_calm;
    window  = 0;
    rx_calm = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      window++;
      if (window % 128 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        res_ready <= 1'b0;
        for (hold_left = LONG_HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk);
      end else if (!quiet_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Command stimulus and verdict.
  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every positional access is out of range.
    send_command(OP_GET, 1, 0);
    send_command(OP_DELETE, 1, 0);
    send_command(OP_UPDATE, 1, 5);
    send_command(OP_INSERT, 2, 5);
    // Appending to an empty list, then inserts at front, end and beyond.
    send_command(OP_APPEND, 0, 32'sh8000_0000);
    send_command(OP_INSERT, 0, 9);
    send_command(OP_INSERT, 1, 32'sh7FFF_FFFF);
    send_command(OP_INSERT, 3, -1);
    send_command(OP_INSERT, 5, 9);
    // Reads across and just outside the list.
    send_command(OP_GET, 0, 0);
    send_command(OP_GET, 1, 0);
    send_command(OP_GET, 2, 0);
    send_command(OP_GET, 3, 0);
    send_command(OP_GET, 4, 0);
    send_command(OP_UPDATE, 2, 0);
    send_command(OP_GET, 2, 0);
    // Deletes past the end, at the end and at the front.
    send_command(OP_DELETE, 4, 0);
    send_command(OP_DELETE, 3, 0);
    send_command(OP_DELETE, 1, 0);
    send_command(OP_GET, 1, 0);
    // Spare op codes, then init over a live list.
    send_command(OP_SPARE_LO, MAX_POSITION, 32'sh5A5A_5A5A);
    send_command(OP_SPARE_HI, CAPACITY, -1);
    send_command(OP_INIT, MAX_POSITION, 12345);
    send_command(OP_GET, MAX_POSITION, 0);
    send_command(OP_GET, 1, 0);
    drain_results();

    // Mixed random traffic.
    repeat (140) send_random_command();
    drain_results();

    // Fill the list to capacity while the result side holds off for a while.
    hold_request = 1'b1;
    while (tracked_length < CAPACITY) begin
      if ($urandom_range(0, 2) == 0) begin
        send_command(OP_INSERT, $urandom_range(1, tracked_length + 1), rand_value());
      end else begin
        send_command(OP_APPEND, $urandom_range(0, MAX_POSITION), rand_value());
      end
    end

    // Full list: growth is refused, bad positions still win over fullness.
    send_command(OP_APPEND, 0, 1);
    send_command(OP_INSERT, 1, 2);
    send_command(OP_INSERT, CAPACITY + 1, 3);
    send_command(OP_INSERT, CAPACITY + 2, 4);
    send_command(OP_INSERT, 0, 5);
    send_command(OP_GET, CAPACITY, 0);
    send_command(OP_GET, CAPACITY + 1, 0);
    send_command(OP_UPDATE, CAPACITY, 32'sh7FFF_FFFF);
    send_command(OP_GET, CAPACITY, 0);
    send_command(OP_DELETE, CAPACITY + 1, 0);
    send_command(OP_DELETE, 1, 0);
    send_command(OP_INSERT, CAPACITY, 32'sh8000_0000);
    send_command(OP_GET, MAX_POSITION, 0);
    send_command(OP_DELETE, CAPACITY, 0);

    // Remaining random traffic; the last stretch runs without idling.
    while (commands_sent < TOTAL_COMMANDS) send_random_command();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d command transactions and %0d result transactions.",
             commands_sent, results_seen);
    $display("The list was filled to its %0d entries %0d time(s); %0d mismatch(es) seen.",
             CAPACITY, full_reached, mismatch_count);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
